/* sv/thv_pkg.sv */
`timescale 1ns / 1ps
package thv_pkg;

   // field widths
   localparam int PIX_W      = 10;
   localparam int HEIGHT_W   = 32;
   localparam int QUAT_W     = 18;
   localparam int DIM_W      = 11;
   localparam int HW_W       = 13;
   localparam int ROW_W      = 16;
   localparam int COL_OUT_W  = 12;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 32;

   // datapath widths
   localparam int QPROD_W = 36;
   localparam int QSUM_W  = 38;
   localparam int COEF_W  = 22;
   localparam int VXY_W   = 20;
   localparam int VZ_W    = 33;
   localparam int PROD_W  = 56;
   localparam int SUM_W   = 58;
   localparam int RND_W   = 34;
   localparam int COLS_W  = 35;

   // horizon storage
   localparam int DEFAULT_MAX_HORIZON = 4096;
   localparam int COL_IDX_W           = 14;
   localparam int LANES               = 16;
   localparam int LANE_W              = 4;
   localparam int FIFO_DEPTH          = 4;

   localparam logic signed [ROW_W-1:0] NEVER_SEEN = 16'sh8000;
   localparam logic signed [RND_W-1:0] ROW_SAT_HI = 34'sd32767;
   localparam logic signed [RND_W-1:0] ROW_SAT_LO = -34'sd32767;

   // divide by three through a reciprocal
   localparam logic [16:0] DIV3_RECIP = 17'd43691;
   localparam int          DIV3_SHIFT = 17;

   // reset values of the registers
   localparam logic signed [QUAT_W-1:0] QUAT_W_RESET  = 18'sd65536;
   localparam logic [DIM_W-1:0]         DIM_RESET     = 11'd1024;
   localparam logic [HW_W-1:0]          HORIZON_RESET = 13'd2508;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_QUAT_X        = 4'd0,
      CSR_QUAT_Y        = 4'd1,
      CSR_QUAT_Z        = 4'd2,
      CSR_QUAT_W        = 4'd3,
      CSR_IMAGE_WIDTH   = 4'd4,
      CSR_IMAGE_HEIGHT  = 4'd5,
      CSR_MEAN_HEIGHT   = 4'd6,
      CSR_HORIZON_WIDTH = 4'd7
   } csr_index_type;

   typedef enum logic {
      BK_IDLE,
      BK_LOOK
   } back_state_type;

   // classified pixel passed from front to back
   typedef struct packed {
      logic                    frame_start;
      logic                    out_of_range;
      logic signed [ROW_W-1:0] row;
      logic [COL_IDX_W-1:0]    col;
   } item_type;

   // round a Q32 coefficient to Q16
   function automatic logic signed [COEF_W-1:0] round_q16(input logic signed [QSUM_W-1:0] e);
      logic signed [QSUM_W-1:0] t;
      begin
         t = e + 38'sd32768;
         return t[QSUM_W-1:16];
      end
   endfunction

endpackage

/* sv/thv_ram.sv */
`timescale 1ns / 1ps
module thv_ram #(
   parameter int WIDTH = 256,
   parameter int DEPTH = 256
) (
   input  logic                                     clock,
   input  logic                                     we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                         wdata,
   input  logic                                     re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* sv/thv_front.sv */
`timescale 1ns / 1ps
module thv_front #(
   parameter int MAX_HORIZON = thv_pkg::DEFAULT_MAX_HORIZON
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  logic                                  frame_start,
   input  logic [thv_pkg::PIX_W-1:0]             pixel_row,
   input  logic [thv_pkg::PIX_W-1:0]             pixel_col,
   input  logic signed [thv_pkg::HEIGHT_W-1:0]   height,
   input  logic signed [thv_pkg::QUAT_W-1:0]     quat_x,
   input  logic signed [thv_pkg::QUAT_W-1:0]     quat_y,
   input  logic signed [thv_pkg::QUAT_W-1:0]     quat_z,
   input  logic signed [thv_pkg::QUAT_W-1:0]     quat_w,
   input  logic [thv_pkg::DIM_W-1:0]             image_width,
   input  logic [thv_pkg::DIM_W-1:0]             image_height,
   input  logic signed [thv_pkg::HEIGHT_W-1:0]   mean_height,
   input  logic [thv_pkg::HW_W-1:0]              horizon_width,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output thv_pkg::item_type                     out_item
);
   import thv_pkg::*;

   logic en;
   logic [4:0] vld_ff, vld_in;

   // horizon_width / 3 and its remainder
   logic [29:0] k_prod;
   logic [HW_W-1:0] k_in, k_ff, mod3;
   logic mod_nz_in, mod_nz_ff;

   // stage 1: quaternion products and centred vector
   logic signed [QPROD_W-1:0] ww_ff, xx_ff, yy_ff, zz_ff, xy_ff, wz_ff, xz_ff, wy_ff, yz_ff,
                              wx_ff;
   logic signed [VXY_W-1:0] vx1_ff, vy1_ff, vx1_in, vy1_in;
   logic signed [VZ_W-1:0]  vz1_ff, vz1_in;
   logic fs1_ff;

   // stage 2: rotation coefficients
   logic signed [COEF_W-1:0] r00_ff, r01_ff, r02_ff, r10_ff, r11_ff, r12_ff;
   logic signed [VXY_W-1:0] vx2_ff, vy2_ff;
   logic signed [VZ_W-1:0]  vz2_ff;
   logic fs2_ff;

   // stage 3: coefficient times vector
   logic signed [PROD_W-1:0] p00_ff, p01_ff, p02_ff, p10_ff, p11_ff, p12_ff;
   logic fs3_ff;

   // stage 4: sums with centre added back
   logic signed [SUM_W-1:0] px_ff, py_ff, px_in, py_in, cx_term, cy_term;
   logic fs4_ff;

   // stage 5: rounding, column offset, range check
   logic signed [SUM_W-1:0]  px_r, py_r;
   logic signed [RND_W-1:0]  row_r, col_r;
   logic signed [COLS_W-1:0] col_s;
   logic signed [ROW_W-1:0]  row_sat;
   logic oor;
   item_type item_in, item_ff;

   assign en       = !vld_ff[4] || out_ready;
   assign in_ready = en;
   assign out_valid = vld_ff[4];
   assign out_item  = item_ff;

   // divide unit, follows the register
   always_comb begin
      k_prod    = 30'(horizon_width) * 30'(DIV3_RECIP);
      k_in      = k_prod[29:DIV3_SHIFT];
      mod3      = horizon_width - (k_in << 1) - k_in;
      mod_nz_in = (mod3 != '0);
   end

   always_ff @(posedge clock) begin
      k_ff      <= k_in;
      mod_nz_ff <= mod_nz_in;
   end

   // stage valid bits
   always_comb begin
      vld_in = {vld_ff[3:0], in_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // centred vector in Q8
   always_comb begin
      vx1_in = $signed({2'b00, pixel_col, 8'h00}) - $signed({2'b00, image_width, 7'h00});
      vy1_in = $signed({2'b00, pixel_row, 8'h00}) - $signed({2'b00, image_height, 7'h00});
      vz1_in = $signed({height[HEIGHT_W-1], height}) -
               $signed({mean_height[HEIGHT_W-1], mean_height});
   end

   // stage 1
   always_ff @(posedge clock) begin
      if (en) begin
         ww_ff  <= quat_w * quat_w;
         xx_ff  <= quat_x * quat_x;
         yy_ff  <= quat_y * quat_y;
         zz_ff  <= quat_z * quat_z;
         xy_ff  <= quat_x * quat_y;
         wz_ff  <= quat_w * quat_z;
         xz_ff  <= quat_x * quat_z;
         wy_ff  <= quat_w * quat_y;
         yz_ff  <= quat_y * quat_z;
         wx_ff  <= quat_w * quat_x;
         vx1_ff <= vx1_in;
         vy1_ff <= vy1_in;
         vz1_ff <= vz1_in;
         fs1_ff <= frame_start;
      end
   end

   // stage 2
   always_ff @(posedge clock) begin
      if (en) begin
         r00_ff <= round_q16(QSUM_W'(ww_ff) + QSUM_W'(xx_ff) - QSUM_W'(yy_ff) - QSUM_W'(zz_ff));
         r01_ff <= round_q16((QSUM_W'(xy_ff) - QSUM_W'(wz_ff)) <<< 1);
         r02_ff <= round_q16((QSUM_W'(xz_ff) + QSUM_W'(wy_ff)) <<< 1);
         r10_ff <= round_q16((QSUM_W'(xy_ff) + QSUM_W'(wz_ff)) <<< 1);
         r11_ff <= round_q16(QSUM_W'(ww_ff) - QSUM_W'(xx_ff) + QSUM_W'(yy_ff) - QSUM_W'(zz_ff));
         r12_ff <= round_q16((QSUM_W'(yz_ff) - QSUM_W'(wx_ff)) <<< 1);
         vx2_ff <= vx1_ff;
         vy2_ff <= vy1_ff;
         vz2_ff <= vz1_ff;
         fs2_ff <= fs1_ff;
      end
   end

   // stage 3
   always_ff @(posedge clock) begin
      if (en) begin
         p00_ff <= PROD_W'(r00_ff * vx2_ff);
         p01_ff <= PROD_W'(r01_ff * vy2_ff);
         p02_ff <= PROD_W'(r02_ff * vz2_ff);
         p10_ff <= PROD_W'(r10_ff * vx2_ff);
         p11_ff <= PROD_W'(r11_ff * vy2_ff);
         p12_ff <= PROD_W'(r12_ff * vz2_ff);
         fs3_ff <= fs2_ff;
      end
   end

   // stage 4, centre back in Q24
   always_comb begin
      cx_term = $signed({{(SUM_W-DIM_W-23){1'b0}}, image_width, 23'h0});
      cy_term = $signed({{(SUM_W-DIM_W-23){1'b0}}, image_height, 23'h0});
      px_in   = SUM_W'(p00_ff) + SUM_W'(p01_ff) + SUM_W'(p02_ff) + cx_term;
      py_in   = SUM_W'(p10_ff) + SUM_W'(p11_ff) + SUM_W'(p12_ff) + cy_term;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff  <= px_in;
         py_ff  <= py_in;
         fs4_ff <= fs3_ff;
      end
   end

   // stage 5
   always_comb begin
      px_r  = px_ff + 58'sd8388608;
      py_r  = py_ff + 58'sd8388608;
      row_r = py_r[SUM_W-1:24];
      col_r = px_r[SUM_W-1:24];
      if (row_r > ROW_SAT_HI) begin
         row_sat = ROW_SAT_HI[ROW_W-1:0];
      end else if (row_r < ROW_SAT_LO) begin
         row_sat = ROW_SAT_LO[ROW_W-1:0];
      end else begin
         row_sat = row_r[ROW_W-1:0];
      end
      // column offset, truncated toward zero
      col_s = $signed({col_r[RND_W-1], col_r}) + $signed({{(COLS_W-HW_W){1'b0}}, k_ff});
      if (col_s < 0 && mod_nz_ff) begin
         col_s = col_s + 35'sd1;
      end
      oor = (col_s < 0) ||
            (col_s >= $signed({{(COLS_W-HW_W){1'b0}}, horizon_width})) ||
            (col_s >= COLS_W'(MAX_HORIZON));
      item_in.frame_start  = fs4_ff;
      item_in.out_of_range = oor;
      item_in.row          = row_sat;
      item_in.col          = oor ? '0 : col_s[COL_IDX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         item_ff <= item_in;
      end
   end

endmodule

/* sv/thv_fifo.sv */
`timescale 1ns / 1ps
module thv_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  thv_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output thv_pkg::item_type pop_item,
   output logic              empty
);
   import thv_pkg::*;

   localparam int PTR_W = $clog2(FIFO_DEPTH);

   item_type            data_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]    wr_ff, rd_ff;
   logic [PTR_W:0]      cnt_ff;

   assign full     = (cnt_ff == (PTR_W + 1)'(FIFO_DEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_item = data_ff[rd_ff];

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wr_ff] <= push_item;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

endmodule

/* sv/thv_back.sv */
`timescale 1ns / 1ps
module thv_back #(
   parameter int MAX_HORIZON = thv_pkg::DEFAULT_MAX_HORIZON
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 q_empty,
   output logic                                 q_pop,
   input  thv_pkg::item_type                    q_item,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_visible,
   output logic                                 rsp_out_of_range,
   output logic signed [thv_pkg::ROW_W-1:0]     rsp_projected_row,
   output logic [thv_pkg::COL_OUT_W-1:0]        rsp_projected_column
);
   import thv_pkg::*;

   localparam int NROWS = MAX_HORIZON / LANES;
   localparam int RA_W  = (NROWS > 1) ? $clog2(NROWS) : 1;
   localparam int WORD_W = LANES * ROW_W;

   back_state_type state_ff, state_in;
   item_type       cur_ff, cur_in;
   logic [NROWS-1:0] rvalid_ff;

   logic re, we, clear, load_rsp, out_free, vis;
   logic [RA_W-1:0]   ra_new, ra_cur;
   logic [LANE_W-1:0] lane_cur;
   logic [WORD_W-1:0] rdata, base, wword;
   logic signed [ROW_W-1:0] stored;

   logic                    rsp_valid_ff, rsp_visible_ff, rsp_oor_ff;
   logic signed [ROW_W-1:0] rsp_row_ff;
   logic [COL_OUT_W-1:0]    rsp_col_ff;

   assign ra_new   = q_item.col[LANE_W +: RA_W];
   assign ra_cur   = cur_ff.col[LANE_W +: RA_W];
   assign lane_cur = cur_ff.col[LANE_W-1:0];
   assign out_free = !rsp_valid_ff || rsp_ready;

   // horizon rows, sixteen columns to a word
   thv_ram #(
      .WIDTH (WORD_W),
      .DEPTH (NROWS)
   ) u_ram (
      .clock (clock),
      .we    (we),
      .waddr (ra_cur),
      .wdata (wword),
      .re    (re),
      .raddr (ra_new),
      .rdata (rdata)
   );

   // compare against stored row, untouched words read as never seen
   always_comb begin
      base   = rvalid_ff[ra_cur] ? rdata : {LANES{NEVER_SEEN}};
      stored = base[lane_cur*ROW_W +: ROW_W];
      vis    = !cur_ff.out_of_range && (cur_ff.row > stored);
      for (int i = 0; i < LANES; i++) begin
         wword[i*ROW_W +: ROW_W] = (LANE_W'(i) == lane_cur) ? cur_ff.row
                                                             : base[i*ROW_W +: ROW_W];
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      cur_in   = cur_ff;
      q_pop    = 1'b0;
      re       = 1'b0;
      we       = 1'b0;
      clear    = 1'b0;
      load_rsp = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               cur_in   = q_item;
               re       = !q_item.out_of_range;
               clear    = q_item.frame_start;
               state_in = BK_LOOK;
            end
         end
         BK_LOOK: begin
            if (out_free) begin
               load_rsp = 1'b1;
               we       = vis;
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   // row valid bits, frame start drops them all
   always_ff @(posedge clock) begin
      if (reset) begin
         rvalid_ff <= '0;
      end else if (clear) begin
         rvalid_ff <= '0;
      end else if (we) begin
         rvalid_ff[ra_cur] <= 1'b1;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_visible_ff <= vis;
         rsp_oor_ff     <= cur_ff.out_of_range;
         rsp_row_ff     <= cur_ff.row;
         rsp_col_ff     <= cur_ff.col[COL_OUT_W-1:0];
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_visible          = rsp_visible_ff;
   assign rsp_out_of_range     = rsp_oor_ff;
   assign rsp_projected_row    = rsp_row_ff;
   assign rsp_projected_column = rsp_col_ff;

endmodule

/* sv/tilted_heightmap_visibility.sv */
`timescale 1ns / 1ps
// Tilted height-map visibility against a horizon.
// Request channel (req_*): one height-map pixel per transaction in raster
// order; req_frame_start empties the horizon before that pixel is handled.
// Response channel (rsp_*): exactly one result per request, in order,
// giving visibility, out-of-range flag, projected row and horizon column.
// Configuration channel (csr_*): index and data, always ready; write only
// while no request is outstanding. Indexes past the register list are ignored.
// From request to response a pixel passes five front end registers, the
// queue, a memory read and the output register.
// The back end finishes one pixel before it takes the next: a read-modify-write
// of the horizon memory (registered read, then compare and write back).
// The rotation front end runs a pixel per cycle into a four-entry queue
// and only stops taking requests once that queue is full.
// Reset: registers take their defaults and the horizon reads as never seen
// at once (one valid bit per memory word), no clearing pass.
// A stalled response holds in the output register; the back end waits and
// the front end keeps filling the queue until it is full.
module tilted_heightmap_visibility #(
   parameter int MAX_HORIZON = thv_pkg::DEFAULT_MAX_HORIZON
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_frame_start,
   input  logic [thv_pkg::PIX_W-1:0]            req_pixel_row,
   input  logic [thv_pkg::PIX_W-1:0]            req_pixel_col,
   input  logic signed [thv_pkg::HEIGHT_W-1:0]  req_height,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_visible,
   output logic                                 rsp_out_of_range,
   output logic signed [thv_pkg::ROW_W-1:0]     rsp_projected_row,
   output logic [thv_pkg::COL_OUT_W-1:0]        rsp_projected_column,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [thv_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [thv_pkg::CSR_DATA_W-1:0]       csr_data
);
   import thv_pkg::*;

   logic signed [QUAT_W-1:0]   quat_x_ff, quat_y_ff, quat_z_ff, quat_w_ff;
   logic [DIM_W-1:0]           image_width_ff, image_height_ff;
   logic signed [HEIGHT_W-1:0] mean_height_ff;
   logic [HW_W-1:0]            horizon_width_ff;

   logic     q_push, q_full, q_pop, q_empty, front_valid;
   item_type front_item, q_item;

   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         quat_x_ff        <= '0;
         quat_y_ff        <= '0;
         quat_z_ff        <= '0;
         quat_w_ff        <= QUAT_W_RESET;
         image_width_ff   <= DIM_RESET;
         image_height_ff  <= DIM_RESET;
         mean_height_ff   <= '0;
         horizon_width_ff <= HORIZON_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_QUAT_X:        quat_x_ff        <= csr_data[QUAT_W-1:0];
            CSR_QUAT_Y:        quat_y_ff        <= csr_data[QUAT_W-1:0];
            CSR_QUAT_Z:        quat_z_ff        <= csr_data[QUAT_W-1:0];
            CSR_QUAT_W:        quat_w_ff        <= csr_data[QUAT_W-1:0];
            CSR_IMAGE_WIDTH:   image_width_ff   <= csr_data[DIM_W-1:0];
            CSR_IMAGE_HEIGHT:  image_height_ff  <= csr_data[DIM_W-1:0];
            CSR_MEAN_HEIGHT:   mean_height_ff   <= csr_data[HEIGHT_W-1:0];
            CSR_HORIZON_WIDTH: horizon_width_ff <= csr_data[HW_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // rotation and classification
   thv_front #(
      .MAX_HORIZON (MAX_HORIZON)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_valid),
      .in_ready      (req_ready),
      .frame_start   (req_frame_start),
      .pixel_row     (req_pixel_row),
      .pixel_col     (req_pixel_col),
      .height        (req_height),
      .quat_x        (quat_x_ff),
      .quat_y        (quat_y_ff),
      .quat_z        (quat_z_ff),
      .quat_w        (quat_w_ff),
      .image_width   (image_width_ff),
      .image_height  (image_height_ff),
      .mean_height   (mean_height_ff),
      .horizon_width (horizon_width_ff),
      .out_valid     (front_valid),
      .out_ready     (!q_full),
      .out_item      (front_item)
   );

   assign q_push = front_valid && !q_full;

   // queue between front and back
   thv_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (front_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_item  (q_item),
      .empty     (q_empty)
   );

   // horizon update
   thv_back #(
      .MAX_HORIZON (MAX_HORIZON)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .q_empty              (q_empty),
      .q_pop                (q_pop),
      .q_item               (q_item),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_visible          (rsp_visible),
      .rsp_out_of_range     (rsp_out_of_range),
      .rsp_projected_row    (rsp_projected_row),
      .rsp_projected_column (rsp_projected_column)
   );

endmodule

/* sv/thv_checker.sv */
`timescale 1ns / 1ps
module thv_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic                                rsp_visible,
   input logic                                rsp_out_of_range,
   input logic signed [thv_pkg::ROW_W-1:0]    rsp_projected_row,
   input logic [thv_pkg::COL_OUT_W-1:0]       rsp_projected_column
);
   import thv_pkg::*;

   // a stalled response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_projected_row) &&
      $stable(rsp_projected_column) && $stable(rsp_visible) && $stable(rsp_out_of_range))
      else $error("response changed while stalled");

   // out of range never marks visible and reports column zero
   a_oor_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_range |-> !rsp_visible && rsp_projected_column == '0)
      else $error("out of range response is not clean");

   // row is saturated, never the never-seen code
   a_row_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_projected_row != NEVER_SEEN)
      else $error("projected row not saturated");

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind tilted_heightmap_visibility thv_checker u_thv_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_valid),
   .rsp_ready            (rsp_ready),
   .rsp_visible          (rsp_visible),
   .rsp_out_of_range     (rsp_out_of_range),
   .rsp_projected_row    (rsp_projected_row),
   .rsp_projected_column (rsp_projected_column)
);

/* sim/tb.sv */
`timescale 1ns / 1ps
module tb;
   import thv_pkg::*;

   localparam int HORIZON_DEPTH = 4096;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_PIXELS = 1750;

   // one predicted response
   typedef struct {
      logic                    visible;
      logic                    out_of_range;
      logic signed [ROW_W-1:0] row;
      logic [COL_OUT_W-1:0]    col;
   } visibility_type;

   // horizon predictor and response checker
   class visibility_scoreboard;
      logic [QUAT_W-1:0]         quat[4];
      logic [DIM_W-1:0]          width_reg, height_reg;
      logic [31:0]               mean_reg;
      logic [HW_W-1:0]           hw_reg;
      logic signed [ROW_W-1:0]   horizon[HORIZON_DEPTH];
      visibility_type            pending[$];
      int                        mismatches;

      function new();
         quat[0] = 0; quat[1] = 0; quat[2] = 0; quat[3] = 18'd65536;
         width_reg = 1024; height_reg = 1024; mean_reg = 0; hw_reg = 2508;
         foreach (horizon[i]) horizon[i] = NEVER_SEEN;
         mismatches = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [31:0] data);
         case (idx)
            CSR_QUAT_X:        quat[0] = data[17:0];
            CSR_QUAT_Y:        quat[1] = data[17:0];
            CSR_QUAT_Z:        quat[2] = data[17:0];
            CSR_QUAT_W:        quat[3] = data[17:0];
            CSR_IMAGE_WIDTH:   width_reg = data[10:0];
            CSR_IMAGE_HEIGHT:  height_reg = data[10:0];
            CSR_MEAN_HEIGHT:   mean_reg = data;
            CSR_HORIZON_WIDTH: hw_reg = data[12:0];
            default: ;
         endcase
      endfunction

      // floor(v / 2^s)
      function longint floor_shift(longint v, int s);
         return v >>> s;
      endfunction

      function longint coef(longint e);
         return floor_shift(e + 32768, 16);
      endfunction

      function void note_pixel(logic fs, logic [9:0] prow, logic [9:0] pcol,
                               logic [31:0] h);
         longint qx, qy, qz, qw, r00, r01, r02, r10, r11, r12;
         longint cx, cy, vx, vy, vz, px, py, row, c, col, hw;
         visibility_type res;
         qx = longint'($signed(quat[0])); qy = longint'($signed(quat[1]));
         qz = longint'($signed(quat[2])); qw = longint'($signed(quat[3]));
         if (fs) foreach (horizon[i]) horizon[i] = NEVER_SEEN;
         r00 = coef(qw*qw + qx*qx - qy*qy - qz*qz);
         r01 = coef(2*(qx*qy - qw*qz));
         r02 = coef(2*(qx*qz + qw*qy));
         r10 = coef(2*(qx*qy + qw*qz));
         r11 = coef(qw*qw - qx*qx + qy*qy - qz*qz);
         r12 = coef(2*(qy*qz - qw*qx));
         cx = longint'(width_reg) * 128;
         cy = longint'(height_reg) * 128;
         vx = longint'(pcol) * 256 - cx;
         vy = longint'(prow) * 256 - cy;
         vz = longint'($signed(h)) - longint'($signed(mean_reg));
         px = r00*vx + r01*vy + r02*vz + cx*65536;
         py = r10*vx + r11*vy + r12*vz + cy*65536;
         row = floor_shift(py + (64'sd1 << 23), 24);
         c = floor_shift(px + (64'sd1 << 23), 24);
         if (row > 32767) row = 32767;
         if (row < -32767) row = -32767;
         hw = longint'(hw_reg);
         col = c + hw / 3;
         if (col < 0 && (hw % 3) != 0) col += 1;
         res.visible = 0;
         res.row = row[15:0];
         res.out_of_range = (col < 0) || (col >= hw) || (col >= HORIZON_DEPTH);
         if (!res.out_of_range) begin
            if (row > longint'(horizon[col])) begin
               res.visible = 1;
               horizon[col] = row[15:0];
            end
         end else begin
            col = 0;
         end
         res.col = col[11:0];
         pending.push_back(res);
      endfunction

      function void check_response(logic vis, logic oor, logic [15:0] row,
                                   logic [11:0] col);
         visibility_type e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response transaction");
            return;
         end
         e = pending.pop_front();
         if (e.visible !== vis || e.out_of_range !== oor || e.row !== row ||
             e.col !== col) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: exp vis %0b oor %0b row %0d col %0d, got %0b %0b %0d %0d",
                        e.visible, e.out_of_range, e.row, e.col, vis, oor,
                        $signed(row), col);
         end
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_ready, req_frame_start = 0;
   logic [9:0] req_pixel_row = 0, req_pixel_col = 0;
   logic signed [31:0] req_height = 0;
   logic rsp_valid, rsp_ready = 0, rsp_visible, rsp_out_of_range;
   logic signed [15:0] rsp_projected_row;
   logic [11:0] rsp_projected_column;
   logic csr_valid = 0, csr_ready;
   logic [3:0] csr_index = 0;
   logic [31:0] csr_data = 0;
   int cycles = 0;
   visibility_scoreboard board = new();

   tilted_heightmap_visibility u_dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // random gap: mostly short, sometimes long
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // response side: random stalls, check each accepted transaction
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tilted_heightmap_visibility test failed");
         $finish;
      end
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            board.check_response(rsp_visible, rsp_out_of_range,
                                 rsp_projected_row, rsp_projected_column);
         rsp_ready <= ($urandom_range(0, 99) < 70) || (cycles % 2000 > 1500);
      end
   end

   // one register write, then valid drops and the channel idles before the task returns
   task automatic csr_write(csr_index_type idx, logic [31:0] data);
      csr_valid <= 1; csr_index <= idx; csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      board.write_reg(idx, data);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   task automatic send_pixel(logic fs, logic [9:0] r, logic [9:0] c, logic [31:0] h,
                             int idle);
      req_valid <= 1; req_frame_start <= fs; req_pixel_row <= r;
      req_pixel_col <= c; req_height <= h;
      do @(posedge clock); while (!req_ready);
      board.note_pixel(fs, r, c, h);
      if (idle > 0) begin
         req_valid <= 0;
         repeat (idle) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_tilt(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                           logic [31:0] w, int iw, int ih, logic [31:0] mh, int hw);
      csr_write(CSR_QUAT_X, x);
      csr_write(CSR_QUAT_Y, y);
      csr_write(CSR_QUAT_Z, z);
      csr_write(CSR_QUAT_W, w);
      csr_write(CSR_IMAGE_WIDTH, iw);
      csr_write(CSR_IMAGE_HEIGHT, ih);
      csr_write(CSR_MEAN_HEIGHT, mh);
      csr_write(CSR_HORIZON_WIDTH, hw);
   endtask

   // small raster frame with random heights
   task automatic random_frame(int rows, int cols);
      for (int r = 0; r < rows; r++)
         for (int c = 0; c < cols; c++)
            send_pixel(r == 0 && c == 0, 10'(r), 10'(c),
                       ($urandom_range(0, 9) == 0) ? $urandom :
                       $signed($urandom_range(0, 16383)) - 8192, gap_len());
   endtask

   initial begin
      int sent;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: reset settings, field extremes, frame start, saturation
      send_pixel(1, 0, 0, 0, 0);
      send_pixel(0, 1023, 1023, 32'h7fffffff, 0);
      send_pixel(0, 1023, 0, 32'h80000000, 1);
      send_pixel(0, 0, 1023, 32'h00000100, 0);
      send_pixel(0, 512, 512, 0, 0);
      send_pixel(0, 512, 512, 0, 0);
      send_pixel(0, 511, 512, 0, 0);
      send_pixel(1, 512, 512, 0, 0);
      drain();
      // tilt about x: height drives the row, saturates
      set_tilt(-32'sd46341, 0, 0, 46341, 8, 8, 32'h100, 20);
      send_pixel(1, 3, 3, 32'h7fffffff, 0);
      send_pixel(0, 3, 3, 32'h80000000, 0);
      send_pixel(0, 0, 0, 32'h200, 0);
      send_pixel(0, 7, 7, 32'h300, 0);
      drain();
      // out-of-range quaternion patterns, negative column offset paths
      set_tilt(32'h1ffff, 32'h20000, 32'h3ffff, 32'h20000, 0, 0,
               32'h80000000, 1);
      send_pixel(1, 1023, 1023, 32'h7fffffff, 0);
      send_pixel(0, 0, 0, 0, 0);
      drain();
      csr_write(CSR_HORIZON_WIDTH, 0);
      send_pixel(0, 5, 5, 0, 0);
      drain();
      set_tilt(0, 0, 65536, 0, 1024, 1024, 32'h7fffffff, 4096);
      send_pixel(1, 1023, 1023, 32'h80000000, 0);
      send_pixel(0, 0, 1023, 0, 0);
      send_pixel(0, 1023, 0, 0, 0);
      drain();

      // random phases: fresh tilts, small frames
      sent = 0;
      while (sent < RANDOM_PIXELS) begin
         int rows, cols, iw;
         rows = $urandom_range(2, 8);
         cols = $urandom_range(2, 8);
         iw = $urandom_range(1, 100) == 1 ? 1024 : $urandom_range(0, 16);
         set_tilt($signed($urandom_range(0, 131072)) - 65536,
                  $signed($urandom_range(0, 131072)) - 65536,
                  $signed($urandom_range(0, 131072)) - 65536,
                  ($urandom_range(0, 7) == 0) ? $urandom :
                  $signed($urandom_range(0, 131072)) - 65536,
                  iw, $urandom_range(0, 16), $signed($urandom_range(0, 4095)) - 2048,
                  ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191)
                                              : $urandom_range(4, 40));
         if ($urandom_range(0, 4) == 0) begin
            // noise: random positions and flags
            for (int i = 0; i < rows * cols; i++)
               send_pixel(1'($urandom_range(0, 1)), 10'($urandom), 10'($urandom),
                          $urandom, gap_len());
         end else begin
            random_frame(rows, cols);
         end
         sent += rows * cols;
         drain();
      end

      drain();
      if (board.mismatches == 0 && board.pending.size() == 0)
         $display("tilted_heightmap_visibility test passed");
      else
         $display("tilted_heightmap_visibility test failed");
      $finish;
   end
endmodule

/* files.f */
sv/thv_pkg.sv
sv/thv_ram.sv
sv/thv_front.sv
sv/thv_fifo.sv
sv/thv_back.sv
sv/tilted_heightmap_visibility.sv
sv/thv_checker.sv
sim/tb.sv
